/* hw/rtl/sfl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_pkg: shared types and constants
// Geometry, entry layout and helper functions for the segmented LRU
// replacement block with frequency promotion.
// ----------------------------------------------------------------------------
package sfl_pkg;

	// Cache geometry
	localparam int NUM_SETS        = 2048;
	localparam int SET_WAYS        = 16;
	localparam int PROTECTED_SLOTS = 6;
	localparam int FREQ_WIDTH      = 2;

	// Segment sizes; the protected segment always leaves one probationary way
	localparam int PROT_N = (PROTECTED_SLOTS < SET_WAYS) ? PROTECTED_SLOTS : (SET_WAYS - 1);
	localparam int PROB_N = SET_WAYS - PROT_N;

	// Fixed field widths of the transaction ports
	localparam int SET_IN_W  = 11;
	localparam int WAY_IN_W  = 4;
	localparam int ADDR_IN_W = 48;
	localparam int TAG_LSB   = 6;
	localparam int TAG_W     = ADDR_IN_W - TAG_LSB;
	localparam int AGE_W     = 8;
	localparam int THR_W     = 2;
	localparam int CMP_W     = 4;
	localparam int STEP_W    = 4;

	// Storage addressing: {set, way}
	localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
	localparam int WAY_W  = $clog2(SET_WAYS);
	localparam int ADDR_W = SET_W + WAY_W;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_PROMOTE_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET = 2'd2;

	localparam logic [AGE_W-1:0] AGE_MAX       = '1;
	localparam logic [AGE_W-1:0] PROB_LAST_AGE = AGE_W'(PROB_N - 1);
	localparam logic [FREQ_WIDTH-1:0] FREQ_SAT = '1;

	// Number of compare-subtract steps that fold set_index into range
	function automatic int mod_steps();
		int n;
		n = 0;
		for (int k = 0; k < SET_IN_W; k++) begin
			if ((longint'(NUM_SETS) << k) < (longint'(1) << SET_IN_W))
				n++;
		end
		return n;
	endfunction

	localparam int MOD_STEPS = mod_steps();

	// NUM_SETS shifted left by k, only used for steps that fit the field
	function automatic logic [SET_IN_W-1:0] mod_const(logic [STEP_W-1:0] k);
		logic [31:0] c;
		c = 32'(NUM_SETS) << k;
		return c[SET_IN_W-1:0];
	endfunction

	// One metadata slot
	typedef struct packed {
		logic                  valid;
		logic [FREQ_WIDTH-1:0] freq;
		logic [AGE_W-1:0]      age;
		logic [TAG_W-1:0]      tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Operations of the shared slot unit
	typedef enum logic [2:0] {
		OP_SCAN = 3'b001,
		OP_MRU  = 3'b010,
		OP_PUT  = 3'b100
	} alu_op_t;

	typedef struct packed {
		alu_op_t               op;
		logic                  sel;
		logic                  promote;
		logic [AGE_W-1:0]      old_age;
		logic [AGE_W-1:0]      best_age;
		logic [FREQ_WIDTH-1:0] new_freq;
		logic                  src_valid;
		logic [TAG_W-1:0]      src_tag;
	} alu_cmd_t;

	typedef struct packed {
		entry_t wdata;
		logic   ge;
		logic   free;
	} alu_res_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		entry_t            wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	function automatic logic [AGE_W-1:0] age_inc(logic [AGE_W-1:0] a);
		return (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
	endfunction

	function automatic logic [FREQ_WIDTH-1:0] freq_inc(logic [FREQ_WIDTH-1:0] f);
		return (f == FREQ_SAT) ? FREQ_SAT : f + 1'b1;
	endfunction

	// Age after reset: slot position inside its own segment
	function automatic logic [AGE_W-1:0] reset_age(logic [WAY_W-1:0] w);
		logic [WAY_W:0] ww;
		ww = {1'b0, w};
		if (ww < (WAY_W+1)'(PROT_N))
			return AGE_W'(ww);
		return AGE_W'(ww - (WAY_W+1)'(PROT_N));
	endfunction

endpackage

/* hw/rtl/sfl_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_ram: generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/sfl_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_alu: shared slot unit
// One age comparator and the slot rewrite used by every pass of the
// sequencer: MRU aging, fill/copy into a slot, and oldest/free scans.
// ----------------------------------------------------------------------------
module sfl_alu (
	input  sfl_pkg::alu_cmd_t cmd,
	input  sfl_pkg::entry_t   rd,
	output sfl_pkg::alu_res_t res
);
	import sfl_pkg::*;

	logic [AGE_W-1:0] cmp_b;
	logic             lt;
	entry_t           wd;

	// Single comparator: against best age when scanning, else the old MRU age
	always_comb begin
		cmp_b = (cmd.op == OP_SCAN) ? cmd.best_age : cmd.old_age;
		lt    = rd.age < cmp_b;
	end

	// Slot rewrite
	always_comb begin
		wd = rd;
		case (cmd.op)
			OP_MRU: begin
				if (cmd.sel) begin
					if (cmd.promote) begin
						wd.valid = 1'b0;
						wd.freq  = '0;
						wd.age   = PROB_LAST_AGE;
						wd.tag   = '0;
					end else begin
						wd.freq = cmd.new_freq;
						wd.age  = '0;
					end
				end else if (rd.valid && lt) begin
					wd.age = age_inc(rd.age);
				end
			end
			OP_PUT: begin
				if (cmd.sel) begin
					wd.valid = cmd.src_valid;
					wd.freq  = cmd.new_freq;
					wd.age   = '0;
					wd.tag   = cmd.src_tag;
				end else if (rd.valid) begin
					wd.age = age_inc(rd.age);
				end
			end
			default: ;
		endcase
	end

	assign res.wdata = wd;
	assign res.ge    = !lt;
	assign res.free  = !rd.valid;

endmodule

/* hw/rtl/sfl_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfl_ctrl: pass sequencer
// Clears the metadata store after reset, folds the set index, then runs
// read/modify/write passes over one segment of the set through the
// shared slot unit.
// ----------------------------------------------------------------------------
module sfl_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          kind,
	input  logic [sfl_pkg::SET_IN_W-1:0]  set_index,
	input  logic [sfl_pkg::WAY_IN_W-1:0]  way,
	input  logic                          hit,
	input  logic [sfl_pkg::ADDR_IN_W-1:0] line_address,
	input  logic [sfl_pkg::THR_W-1:0]     thr,
	output logic                          busy,
	output logic                          done,
	output logic [sfl_pkg::WAY_IN_W-1:0]  victim_way,
	output sfl_pkg::ram_req_t             ram_req,
	input  sfl_pkg::entry_t               ram_rdata,
	output sfl_pkg::alu_cmd_t             alu_cmd,
	input  sfl_pkg::alu_res_t             alu_res
);
	import sfl_pkg::*;

	localparam int WX_W = WAY_IN_W + 2;
	localparam logic [WAY_W-1:0] PROT_LAST = WAY_W'(PROT_N - 1);
	localparam logic [WAY_W-1:0] PROB_LAST = WAY_W'(PROB_N - 1);

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_MOD   = 9'b000000100,
		ST_DISP  = 9'b000001000,
		ST_TGT   = 9'b000010000,
		ST_VICT  = 9'b000100000,
		ST_MRU   = 9'b001000000,
		ST_OLD   = 9'b010000000,
		ST_PUT   = 9'b100000000
	} state_t;

	state_t                state_q;
	logic [ADDR_W-1:0]     clr_q;
	logic [STEP_W-1:0]     step_q;
	logic [SET_IN_W-1:0]   set_q;
	logic                  kind_q;
	logic [WAY_IN_W-1:0]   way_q;
	logic                  hit_q;
	logic [TAG_W-1:0]      tag_q;
	logic                  seg_prob_q;
	logic [WAY_W-1:0]      sel_q;
	logic [WAY_W-1:0]      cnt_q;
	logic [WAY_W-1:0]      last_q;
	logic                  iss_q;
	logic [WAY_W-1:0]      idx_s1;
	logic                  vld_s1;
	logic [AGE_W-1:0]      old_age_q;
	logic [FREQ_WIDTH-1:0] new_freq_q;
	logic                  promote_q;
	logic                  src_valid_q;
	logic [TAG_W-1:0]      src_tag_q;
	logic [AGE_W-1:0]      best_age_q;
	logic [WAY_W-1:0]      best_idx_q;
	logic                  found_q;
	logic [WAY_W-1:0]      free_idx_q;
	logic                  done_q;
	logic [WAY_IN_W-1:0]   victim_q;

	logic [WX_W-1:0]       way_x;
	logic                  way_ok;
	logic                  way_prot;
	logic [WAY_W-1:0]      prob_idx;
	logic [WAY_W-1:0]      seg_base;
	logic [WAY_W-1:0]      rd_way;
	logic [WAY_W-1:0]      wr_way;
	logic                  pass_end;
	logic                  is_scan;
	logic [FREQ_WIDTH-1:0] tgt_freq;
	logic                  tgt_promote;
	logic [SET_IN_W-1:0]   mod_c;
	logic                  step_ge;
	logic                  step_free;
	logic [AGE_W-1:0]      best_age_n;
	logic [WAY_W-1:0]      best_idx_n;
	logic                  found_n;
	logic [WAY_W-1:0]      free_idx_n;
	logic [WAY_W-1:0]      pick_idx;
	logic [WAY_W:0]        victim_sum;

	// Way decode for the captured transaction
	always_comb begin
		way_x    = {2'b00, way_q};
		way_ok   = way_x < WX_W'(SET_WAYS);
		way_prot = way_x < WX_W'(PROT_N);
		prob_idx = WAY_W'(way_x - WX_W'(PROT_N));
	end

	// Segment addressing and pass bookkeeping
	always_comb begin
		seg_base = seg_prob_q ? WAY_W'(PROT_N) : '0;
		rd_way   = seg_base + cnt_q;
		wr_way   = seg_base + idx_s1;
		pass_end = vld_s1 && (idx_s1 == last_q);
		is_scan  = (state_q == ST_VICT) || (state_q == ST_OLD);
		mod_c    = mod_const(step_q);
	end

	// Target slot: bumped frequency and promotion decision
	always_comb begin
		tgt_freq    = freq_inc(ram_rdata.freq);
		tgt_promote = seg_prob_q && (CMP_W'(tgt_freq) >= CMP_W'(thr));
	end

	// Scan accumulators including the slot returned this cycle
	always_comb begin
		step_ge    = vld_s1 && alu_res.ge;
		step_free  = vld_s1 && alu_res.free && !found_q;
		best_age_n = step_ge ? ram_rdata.age : best_age_q;
		best_idx_n = step_ge ? idx_s1 : best_idx_q;
		found_n    = found_q || step_free;
		free_idx_n = step_free ? idx_s1 : free_idx_q;
		pick_idx   = found_n ? free_idx_n : best_idx_n;
		victim_sum = (WAY_W+1)'(PROT_N) + {1'b0, pick_idx};
	end

	// Storage requests: clearing pass or write-back from the slot unit
	always_comb begin
		ram_req.raddr = {SET_W'(set_q), rd_way};
		if (state_q == ST_CLEAR) begin
			ram_req.we          = 1'b1;
			ram_req.waddr       = clr_q;
			ram_req.wdata.valid = 1'b0;
			ram_req.wdata.freq  = '0;
			ram_req.wdata.age   = reset_age(clr_q[WAY_W-1:0]);
			ram_req.wdata.tag   = '0;
		end else begin
			ram_req.we    = vld_s1 && ((state_q == ST_MRU) || (state_q == ST_PUT));
			ram_req.waddr = {SET_W'(set_q), wr_way};
			ram_req.wdata = alu_res.wdata;
		end
	end

	// Slot unit command
	always_comb begin
		case (state_q)
			ST_MRU:  alu_cmd.op = OP_MRU;
			ST_PUT:  alu_cmd.op = OP_PUT;
			default: alu_cmd.op = OP_SCAN;
		endcase
		alu_cmd.sel       = idx_s1 == sel_q;
		alu_cmd.promote   = promote_q;
		alu_cmd.old_age   = old_age_q;
		alu_cmd.best_age  = best_age_q;
		alu_cmd.new_freq  = new_freq_q;
		alu_cmd.src_valid = src_valid_q;
		alu_cmd.src_tag   = src_tag_q;
	end

	// Control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			iss_q   <= 1'b0;
			vld_s1  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;

			// read issue counter, one slot per cycle
			if (iss_q) begin
				if (cnt_q == last_q)
					iss_q <= 1'b0;
				else
					cnt_q <= cnt_q + 1'b1;
			end
			vld_s1 <= iss_q;
			idx_s1 <= cnt_q;

			if (is_scan) begin
				best_age_q <= best_age_n;
				best_idx_q <= best_idx_n;
				found_q    <= found_n;
				free_idx_q <= free_idx_n;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q)
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (start) begin
						kind_q  <= kind;
						set_q   <= set_index;
						way_q   <= way;
						hit_q   <= hit;
						tag_q   <= line_address[ADDR_IN_W-1:TAG_LSB];
						step_q  <= STEP_W'(MOD_STEPS - 1);
						state_q <= (MOD_STEPS > 0) ? ST_MOD : ST_DISP;
					end
				end
				ST_MOD: begin
					if (set_q >= mod_c)
						set_q <= set_q - mod_c;
					if (step_q == '0)
						state_q <= ST_DISP;
					else
						step_q <= step_q - 1'b1;
				end
				ST_DISP: begin
					if (!kind_q) begin
						seg_prob_q <= 1'b1;
						cnt_q      <= '0;
						last_q     <= PROB_LAST;
						iss_q      <= 1'b1;
						best_age_q <= '0;
						best_idx_q <= '0;
						found_q    <= 1'b0;
						state_q    <= ST_VICT;
					end else if (!way_ok || (way_prot && !hit_q)) begin
						state_q <= ST_IDLE;
					end else if (way_prot) begin
						seg_prob_q <= 1'b0;
						sel_q      <= WAY_W'(way_x);
						cnt_q      <= WAY_W'(way_x);
						last_q     <= WAY_W'(way_x);
						iss_q      <= 1'b1;
						state_q    <= ST_TGT;
					end else if (hit_q) begin
						seg_prob_q <= 1'b1;
						sel_q      <= prob_idx;
						cnt_q      <= prob_idx;
						last_q     <= prob_idx;
						iss_q      <= 1'b1;
						state_q    <= ST_TGT;
					end else begin
						// miss fill of a probationary slot
						seg_prob_q  <= 1'b1;
						sel_q       <= prob_idx;
						cnt_q       <= '0;
						last_q      <= PROB_LAST;
						iss_q       <= 1'b1;
						src_valid_q <= 1'b1;
						new_freq_q  <= FREQ_WIDTH'(1);
						src_tag_q   <= tag_q;
						state_q     <= ST_PUT;
					end
				end
				ST_TGT: begin
					if (pass_end) begin
						old_age_q   <= ram_rdata.age;
						new_freq_q  <= tgt_freq;
						promote_q   <= tgt_promote;
						src_valid_q <= ram_rdata.valid;
						src_tag_q   <= ram_rdata.tag;
						cnt_q       <= '0;
						last_q      <= seg_prob_q ? PROB_LAST : PROT_LAST;
						iss_q       <= 1'b1;
						state_q     <= ST_MRU;
					end
				end
				ST_MRU: begin
					if (pass_end) begin
						if (promote_q) begin
							seg_prob_q <= 1'b0;
							cnt_q      <= '0;
							last_q     <= PROT_LAST;
							iss_q      <= 1'b1;
							best_age_q <= '0;
							best_idx_q <= '0;
							found_q    <= 1'b0;
							state_q    <= ST_OLD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_OLD: begin
					// oldest protected slot receives the promoted entry
					if (pass_end) begin
						sel_q   <= best_idx_n;
						cnt_q   <= '0;
						last_q  <= PROT_LAST;
						iss_q   <= 1'b1;
						state_q <= ST_PUT;
					end
				end
				ST_PUT: begin
					if (pass_end)
						state_q <= ST_IDLE;
				end
				ST_VICT: begin
					if (pass_end) begin
						done_q   <= 1'b1;
						victim_q <= WAY_IN_W'(victim_sum);
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy       = state_q != ST_IDLE;
	assign done       = done_q;
	assign victim_way = victim_q;

endmodule

/* hw/rtl/segmented_freq_lru_replacement.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segmented_freq_lru_replacement: segmented LRU metadata with promotion
// Per-set replacement state for a 16-way cache split into protected and
// probationary segments; answers victim queries and applies access updates.
//
//  channel   | signals                                  | transaction
//  ----------+------------------------------------------+--------------------------
//  command   | start, busy, kind, set_index, way, hit,  | start high while busy low
//            | line_address                             |
//  result    | done, victim_way                         | done high for one cycle
//  config    | psel, penable, pwrite, paddr, pwdata,    | psel & penable & pwrite
//            | prdata, pready                           | (pready tied high)
//
// Transactions are paced by the single storage read port, one slot
// visited per cycle: victim queries and fills pass over the probationary
// segment, hits read the target slot and then pass over its segment,
// promotion adds passes over the protected segment, an ignored update
// returns to idle, and set_index is first folded when NUM_SETS does not cover its range.
// After reset a clearing pass over all 2**ADDR_W (32768) slots holds busy high.
// The result receiver cannot stall; one query yields one done pulse.
// ----------------------------------------------------------------------------
module segmented_freq_lru_replacement (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sfl_pkg::PADDR_W-1:0]   paddr,
	input  logic [sfl_pkg::PDATA_W-1:0]   pwdata,
	output logic [sfl_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready,
	input  logic                          start,
	output logic                          busy,
	input  logic                          kind,
	input  logic [sfl_pkg::SET_IN_W-1:0]  set_index,
	input  logic [sfl_pkg::WAY_IN_W-1:0]  way,
	input  logic                          hit,
	input  logic [sfl_pkg::ADDR_IN_W-1:0] line_address,
	output logic                          done,
	output logic [sfl_pkg::WAY_IN_W-1:0]  victim_way
);
	import sfl_pkg::*;

	logic [THR_W-1:0]  thr_q;
	logic              reg_idx;
	logic              cfg_wr;
	ram_req_t          ram_req;
	logic [ENTRY_W-1:0] ram_rdata_raw;
	entry_t            ram_rdata;
	alu_cmd_t          alu_cmd;
	alu_res_t          alu_res;

	// Register decode
	assign reg_idx = paddr[PADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign pready  = 1'b1;
	assign prdata  = (reg_idx == REG_PROMOTE_THRESHOLD) ? PDATA_W'(thr_q) : '0;

	// Promotion threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr && (reg_idx == REG_PROMOTE_THRESHOLD)) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	sfl_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.kind         (kind),
		.set_index    (set_index),
		.way          (way),
		.hit          (hit),
		.line_address (line_address),
		.thr          (thr_q),
		.busy         (busy),
		.done         (done),
		.victim_way   (victim_way),
		.ram_req      (ram_req),
		.ram_rdata    (ram_rdata),
		.alu_cmd      (alu_cmd),
		.alu_res      (alu_res)
	);

	sfl_alu u_alu (
		.cmd (alu_cmd),
		.rd  (ram_rdata),
		.res (alu_res)
	);

	// Metadata store, one slot per entry, addressed {set, way}
	sfl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (2**ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata_raw)
	);

	assign ram_rdata = ram_rdata_raw;

endmodule
